// ===== hw/rtl/sfcs_pkg.sv =====
package sfcs_pkg;

    localparam int unsigned PAGE_BYTES       = 256;
    localparam int unsigned SECTOR_BYTES     = 4096;
    localparam int unsigned PAGES_PER_SECTOR =
        (SECTOR_BYTES / PAGE_BYTES) > 0 ? (SECTOR_BYTES / PAGE_BYTES) : 1;
    localparam int unsigned CNT_W            = 25;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_HOST  = 2'd1;
    localparam logic [1:0] OP_FLASH = 2'd2;

    localparam logic [3:0] CMD_READ     = 4'd0;
    localparam logic [3:0] CMD_ERASE    = 4'd1;
    localparam logic [3:0] CMD_WRITE    = 4'd2;
    localparam logic [3:0] CMD_ERASE_WR = 4'd3;
    localparam logic [3:0] CMD_RDSTATUS = 4'd4;
    localparam logic [3:0] CMD_WRSTATUS = 4'd5;
    localparam logic [3:0] CMD_MANUID   = 4'd6;
    localparam logic [3:0] CMD_UNIQUEID = 4'd7;
    localparam logic [3:0] CMD_JEDEC    = 4'd8;

    localparam logic [7:0] SPI_WREN  = 8'h06;
    localparam logic [7:0] SPI_RDSR  = 8'h05;
    localparam logic [7:0] SPI_WRSR  = 8'h01;
    localparam logic [7:0] SPI_READ  = 8'h03;
    localparam logic [7:0] SPI_SE    = 8'h20;
    localparam logic [7:0] SPI_PP    = 8'h02;
    localparam logic [7:0] SPI_MID   = 8'h90;
    localparam logic [7:0] SPI_UID   = 8'h4B;
    localparam logic [7:0] SPI_JID   = 8'h9F;
    localparam logic [7:0] BUSY_MASK = 8'h01;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WREN, PH_FRAME, PH_HOST, PH_POLL_CMD, PH_POLL_RD
    } phase_t;

    typedef enum logic [3:0] {
        FK_NONE, FK_READ, FK_SE, FK_PP, FK_RDSR, FK_WRSR, FK_MID, FK_UID, FK_JID
    } kind_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  command;
        logic [23:0] address;
        logic [23:0] length;
        logic [7:0]  data_byte;
        logic [7:0]  spi_byte;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       need_data;
        logic       done_res;
        logic       rejected;
    } out_item_t;

    function automatic logic [7:0] kind_opcode(kind_t k);
        case (k)
            FK_READ: return SPI_READ;
            FK_SE:   return SPI_SE;
            FK_PP:   return SPI_PP;
            FK_RDSR: return SPI_RDSR;
            FK_WRSR: return SPI_WRSR;
            FK_MID:  return SPI_MID;
            FK_UID:  return SPI_UID;
            default: return SPI_JID;
        endcase
    endfunction

    function automatic logic [2:0] kind_header(kind_t k);
        case (k)
            FK_READ, FK_SE, FK_PP, FK_MID: return 3'd4;
            FK_UID:  return 3'd5;
            default: return 3'd1;
        endcase
    endfunction

    function automatic logic kind_rx(kind_t k);
        return k == FK_READ || k == FK_RDSR || k == FK_MID || k == FK_UID || k == FK_JID;
    endfunction

    function automatic logic kind_addr(kind_t k);
        return k == FK_READ || k == FK_SE || k == FK_PP;
    endfunction

endpackage

// ===== hw/rtl/spi_flash_command_sequencer_core.sv =====
// channel  ports                  payload      beat accepted when
// input    s_valid s_ready s_data in_item_t    s_valid && s_ready
// result   m_valid m_ready m_data out_item_t   m_valid && m_ready
//
// One result beat for every input beat, registered and valid in the cycle after acceptance.
// A beat is accepted in every cycle while the result register is empty or drained.
// Sequencer state and result register update in the same edge; no other pipeline.
// aresetn (synchronous, active low) returns the sequencer to idle and empties the output.
// A stalled result holds; the input then stalls too.
module spi_flash_command_sequencer_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sfcs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sfcs_pkg::out_item_t m_data
);
    import sfcs_pkg::*;

    phase_t           phase_reg, phase_next;
    kind_t            kind_reg, kind_next;
    logic [3:0]       cmd_reg, cmd_next;
    logic [23:0]      ptr_reg, ptr_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] fidx_reg, fidx_next;
    logic [CNT_W-1:0] flen_reg, flen_next;
    logic [4:0]       pages_reg, pages_next;
    logic             pidx_reg, pidx_next;
    logic             m_valid_reg;
    out_item_t        m_data_reg;
    out_item_t        res;

    logic             ok, do_open, do_send;
    logic [CNT_W-1:0] size, span, pp_len;
    logic [2:0]       hdr;

    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        cmd_next   = cmd_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        fidx_next  = fidx_reg;
        flen_next  = flen_reg;
        pages_next = pages_reg;
        pidx_next  = pidx_reg;
        res        = '0;
        ok         = 1'b1;
        do_open    = 1'b0;
        do_send    = 1'b0;
        span       = '0;
        size       = (flen_reg >= CNT_W'(4)) ? flen_reg - CNT_W'(4) : '0;
        if (size > left_reg) begin
            size = left_reg;
        end

        unique case (phase_reg)
            PH_IDLE: begin
                if (s_data.opcode != OP_START || s_data.command > CMD_JEDEC) begin
                    ok = 1'b0;
                end else begin
                    cmd_next   = s_data.command;
                    pages_next = '0;
                    pidx_next  = 1'b0;
                    ptr_next   = s_data.address;
                    left_next  = '0;
                    unique case (s_data.command)
                        CMD_READ: begin
                            left_next = {1'b0, s_data.length};
                            kind_next = FK_READ;
                            do_open   = 1'b1;
                        end
                        CMD_ERASE: begin
                            left_next = ({1'b0, s_data.length} + CNT_W'(SECTOR_BYTES - 1))
                                        & ~CNT_W'(SECTOR_BYTES - 1);
                            kind_next = FK_SE;
                        end
                        CMD_WRITE: begin
                            left_next = ({1'b0, s_data.length} + CNT_W'(PAGE_BYTES - 1))
                                        & ~CNT_W'(PAGE_BYTES - 1);
                            kind_next = FK_PP;
                        end
                        CMD_ERASE_WR: begin
                            span      = ({1'b0, s_data.address} + CNT_W'(SECTOR_BYTES - 1))
                                        & ~CNT_W'(SECTOR_BYTES - 1);
                            ptr_next  = span[23:0];
                            left_next = {1'b0, s_data.length};
                            kind_next = FK_SE;
                        end
                        CMD_RDSTATUS: begin kind_next = FK_RDSR; do_open = 1'b1; end
                        CMD_WRSTATUS: begin kind_next = FK_WRSR; end
                        CMD_MANUID:   begin kind_next = FK_MID;  do_open = 1'b1; end
                        CMD_UNIQUEID: begin kind_next = FK_UID;  do_open = 1'b1; end
                        default:      begin kind_next = FK_JID;  do_open = 1'b1; end
                    endcase
                    if (!do_open) begin
                        if (s_data.command == CMD_WRSTATUS || left_next != '0) begin
                            phase_next   = PH_WREN;
                            res.tx_valid = 1'b1;
                            res.tx_byte  = SPI_WREN;
                            res.frame_end = 1'b1;
                        end else begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                    end
                end
            end
            PH_HOST: begin
                if (s_data.opcode != OP_HOST) begin
                    ok = 1'b0;
                end else begin
                    res.tx_valid  = 1'b1;
                    res.tx_byte   = s_data.data_byte;
                    res.frame_end = (fidx_reg + CNT_W'(1)) == flen_reg;
                    phase_next    = PH_FRAME;
                end
            end
            PH_WREN: begin
                if (s_data.opcode != OP_FLASH) ok = 1'b0;
                else do_open = 1'b1;
            end
            PH_FRAME: begin
                if (s_data.opcode != OP_FLASH) begin
                    ok = 1'b0;
                end else begin
                    if (kind_rx(kind_reg) && fidx_reg >= CNT_W'(kind_header(kind_reg))) begin
                        res.rx_valid = 1'b1;
                        res.rx_byte  = s_data.spi_byte;
                    end
                    fidx_next = fidx_reg + CNT_W'(1);
                    if (fidx_next >= flen_reg) begin
                        if (kind_reg == FK_SE || kind_reg == FK_PP || kind_reg == FK_WRSR) begin
                            phase_next   = PH_POLL_CMD;
                            res.tx_valid = 1'b1;
                            res.tx_byte  = SPI_RDSR;
                        end else begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                    end else begin
                        do_send = 1'b1;
                    end
                end
            end
            PH_POLL_CMD: begin
                if (s_data.opcode != OP_FLASH) begin
                    ok = 1'b0;
                end else begin
                    pidx_next    = 1'b0;
                    phase_next   = PH_POLL_RD;
                    res.tx_valid = 1'b1;
                end
            end
            PH_POLL_RD: begin
                if (s_data.opcode != OP_FLASH) begin
                    ok = 1'b0;
                end else if (!pidx_reg) begin
                    pidx_next     = 1'b1;
                    res.tx_valid  = 1'b1;
                    res.frame_end = 1'b1;
                end else if ((s_data.spi_byte & BUSY_MASK) != '0) begin
                    phase_next   = PH_POLL_CMD;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = SPI_RDSR;
                end else begin
                    phase_next = PH_WREN;
                    case (cmd_reg)
                        CMD_ERASE: begin
                            ptr_next  = ptr_reg + 24'(SECTOR_BYTES);
                            left_next = left_reg - ((left_reg >= CNT_W'(SECTOR_BYTES))
                                        ? CNT_W'(SECTOR_BYTES) : left_reg);
                            kind_next = FK_SE;
                            if (left_next == '0) phase_next = PH_IDLE;
                        end
                        CMD_WRITE: begin
                            ptr_next  = ptr_reg + size[23:0];
                            left_next = left_reg - size;
                            kind_next = FK_PP;
                            if (left_next == '0) phase_next = PH_IDLE;
                        end
                        CMD_ERASE_WR: begin
                            if (kind_reg == FK_SE) begin
                                pages_next = '0;
                                kind_next  = FK_PP;
                            end else begin
                                ptr_next   = ptr_reg + size[23:0];
                                left_next  = left_reg - size;
                                pages_next = pages_reg + 5'd1;
                                if (left_next == '0) phase_next = PH_IDLE;
                                else if (pages_next < 5'(PAGES_PER_SECTOR)) kind_next = FK_PP;
                                else kind_next = FK_SE;
                            end
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                    if (phase_next == PH_IDLE) begin
                        res.done_res = 1'b1;
                    end else begin
                        res.tx_valid  = 1'b1;
                        res.tx_byte   = SPI_WREN;
                        res.frame_end = 1'b1;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
                ok = 1'b0;
            end
        endcase

        pp_len = (left_next > CNT_W'(PAGE_BYTES)) ? CNT_W'(PAGE_BYTES) : left_next;
        if (do_open) begin
            fidx_next = '0;
            do_send   = 1'b1;
            case (kind_next)
                FK_READ:         flen_next = CNT_W'(4) + left_next;
                FK_PP:           flen_next = CNT_W'(4) + pp_len;
                FK_RDSR, FK_WRSR: flen_next = CNT_W'(3);
                FK_MID:          flen_next = CNT_W'(6);
                FK_UID:          flen_next = CNT_W'(13);
                default:         flen_next = CNT_W'(4);
            endcase
        end

        hdr = kind_header(kind_next);
        if (do_send) begin
            if (fidx_next < CNT_W'(hdr)) begin
                res.tx_valid  = 1'b1;
                res.frame_end = (fidx_next + CNT_W'(1)) == flen_next;
                phase_next    = PH_FRAME;
                if (fidx_next == '0) begin
                    res.tx_byte = kind_opcode(kind_next);
                end else if (kind_addr(kind_next)) begin
                    case (fidx_next[1:0])
                        2'd1:    res.tx_byte = ptr_next[23:16];
                        2'd2:    res.tx_byte = ptr_next[15:8];
                        default: res.tx_byte = ptr_next[7:0];
                    endcase
                end
            end else if (kind_rx(kind_next)) begin
                res.tx_valid  = 1'b1;
                res.frame_end = (fidx_next + CNT_W'(1)) == flen_next;
                phase_next    = PH_FRAME;
            end else begin
                res.need_data = 1'b1;
                phase_next    = PH_HOST;
            end
        end

        if (!ok) begin
            kind_next    = kind_reg;
            cmd_next     = cmd_reg;
            ptr_next     = ptr_reg;
            left_next    = left_reg;
            fidx_next    = fidx_reg;
            flen_next    = flen_reg;
            pages_next   = pages_reg;
            pidx_next    = pidx_reg;
            if (phase_reg != PH_IDLE && phase_reg != PH_WREN && phase_reg != PH_FRAME &&
                phase_reg != PH_HOST && phase_reg != PH_POLL_CMD &&
                phase_reg != PH_POLL_RD) begin
                phase_next = PH_IDLE;
            end else begin
                phase_next = phase_reg;
            end
            res          = '0;
            res.rejected = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            kind_reg    <= FK_NONE;
            cmd_reg     <= '0;
            ptr_reg     <= '0;
            left_reg    <= '0;
            fidx_reg    <= '0;
            flen_reg    <= '0;
            pages_reg   <= '0;
            pidx_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                cmd_reg   <= cmd_next;
                ptr_reg   <= ptr_next;
                left_reg  <= left_next;
                fidx_reg  <= fidx_next;
                flen_reg  <= flen_next;
                pages_reg <= pages_next;
                pidx_reg  <= pidx_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            m_data_reg <= res;
        end
    end

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rejected |-> !m_data.tx_valid && !m_data.done_res && !m_data.rx_valid)
        else $error("rejected beat carries other fields");
    a_done_no_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> !m_data.tx_valid && !m_data.need_data)
        else $error("done beat requests a transfer");
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted beat gave no result");
    a_need_idle_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.need_data |-> !m_data.tx_valid)
        else $error("data request with transfer");

endmodule

// ===== tb/spi_flash_command_sequencer_core_test.sv =====
`timescale 1ns / 1ps

module spi_flash_command_sequencer_core_test;
    import sfcs_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    spi_flash_command_sequencer_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // sequencer shadow
    phase_t      sq_phase;
    kind_t       sq_kind;
    logic [3:0]  sq_cmd;
    logic [23:0] sq_ptr;
    int unsigned sq_left;
    int unsigned sq_fidx;
    int unsigned sq_flen;
    int unsigned sq_pages;
    bit          sq_pidx;
    out_item_t   sq_res;

    in_item_t  beat_q[$];
    bit        drain_q[$];
    out_item_t staged_q[$];
    out_item_t awaited_q[$];

    int  errors;
    int  beats_in;
    int  beats_out;
    int  starts_made;
    int  gap_in;
    int  gap_out;
    bit  accepted;
    bit  quiet;
    bit  drain_next;

    function automatic logic [7:0] spi_opcode(kind_t k);
        case (k)
            FK_READ: return SPI_READ;
            FK_SE:   return SPI_SE;
            FK_PP:   return SPI_PP;
            FK_RDSR: return SPI_RDSR;
            FK_WRSR: return SPI_WRSR;
            FK_MID:  return SPI_MID;
            FK_UID:  return SPI_UID;
            default: return SPI_JID;
        endcase
    endfunction

    function automatic int unsigned header_len(kind_t k);
        if (k == FK_READ || k == FK_SE || k == FK_PP || k == FK_MID) return 4;
        if (k == FK_UID) return 5;
        return 1;
    endfunction

    function automatic bit returns_data(kind_t k);
        return k == FK_READ || k == FK_RDSR || k == FK_MID || k == FK_UID || k == FK_JID;
    endfunction

    function automatic int unsigned round_to(int unsigned v, int unsigned unit);
        return (v + unit - 1) / unit * unit;
    endfunction

    function void shift_out(logic [7:0] b, bit last);
        sq_res.tx_valid  = 1'b1;
        sq_res.tx_byte   = b;
        sq_res.frame_end = last;
    endfunction

    function void next_frame_byte();
        logic [7:0] b;
        bit last;
        b = 8'h00;
        last = (sq_fidx + 1 == sq_flen);
        if (sq_fidx < header_len(sq_kind)) begin
            if (sq_fidx == 0)
                b = spi_opcode(sq_kind);
            else if ((sq_kind == FK_READ || sq_kind == FK_SE || sq_kind == FK_PP)
                     && sq_fidx <= 3)
                b = 8'(sq_ptr >> (8 * (3 - sq_fidx)));
            shift_out(b, last);
            sq_phase = PH_FRAME;
        end else if (returns_data(sq_kind)) begin
            shift_out(8'h00, last);
            sq_phase = PH_FRAME;
        end else begin
            sq_res.need_data = 1'b1;
            sq_phase = PH_HOST;
        end
    endfunction

    function void open_frame(kind_t k);
        sq_kind = k;
        sq_fidx = 0;
        case (k)
            FK_READ:         sq_flen = 4 + sq_left;
            FK_PP:           sq_flen = 4 + ((sq_left > PAGE_BYTES) ? PAGE_BYTES : sq_left);
            FK_RDSR, FK_WRSR: sq_flen = 3;
            FK_MID:          sq_flen = 6;
            FK_UID:          sq_flen = 13;
            default:         sq_flen = 4;
        endcase
        next_frame_byte();
    endfunction

    function void arm_write(kind_t k);
        sq_kind = k;
        sq_phase = PH_WREN;
        shift_out(SPI_WREN, 1'b1);
    endfunction

    function void poll_status();
        sq_phase = PH_POLL_CMD;
        shift_out(SPI_RDSR, 1'b0);
    endfunction

    function void complete();
        sq_phase = PH_IDLE;
        sq_res.done_res = 1'b1;
    endfunction

    function void ready_again();
        int unsigned size;
        size = (sq_flen >= 4) ? sq_flen - 4 : 0;
        if (size > sq_left) size = sq_left;
        case (sq_cmd)
            CMD_ERASE: begin
                sq_ptr = 24'({8'h00, sq_ptr} + SECTOR_BYTES);
                sq_left -= (sq_left >= SECTOR_BYTES) ? SECTOR_BYTES : sq_left;
                if (sq_left != 0) arm_write(FK_SE); else complete();
            end
            CMD_WRITE: begin
                sq_ptr = 24'({8'h00, sq_ptr} + size);
                sq_left -= size;
                if (sq_left != 0) arm_write(FK_PP); else complete();
            end
            CMD_ERASE_WR: begin
                if (sq_kind == FK_SE) begin
                    sq_pages = 0;
                    arm_write(FK_PP);
                end else begin
                    sq_ptr = 24'({8'h00, sq_ptr} + size);
                    sq_left -= size;
                    sq_pages++;
                    if (sq_left == 0) complete();
                    else if (sq_pages < PAGES_PER_SECTOR) arm_write(FK_PP);
                    else arm_write(FK_SE);
                end
            end
            default: complete();
        endcase
    endfunction

    function bit launch(logic [3:0] cmd, logic [23:0] addr, logic [23:0] len);
        if (cmd > CMD_JEDEC) return 1'b0;
        sq_cmd   = cmd;
        sq_pages = 0;
        sq_pidx  = 1'b0;
        sq_ptr   = addr;
        sq_left  = 0;
        case (cmd)
            CMD_READ: begin
                sq_left = {8'h00, len};
                open_frame(FK_READ);
            end
            CMD_ERASE: begin
                sq_left = round_to({8'h00, len}, SECTOR_BYTES);
                if (sq_left != 0) arm_write(FK_SE); else complete();
            end
            CMD_WRITE: begin
                sq_left = round_to({8'h00, len}, PAGE_BYTES);
                if (sq_left != 0) arm_write(FK_PP); else complete();
            end
            CMD_ERASE_WR: begin
                sq_ptr  = 24'(round_to({8'h00, addr}, SECTOR_BYTES));
                sq_left = {8'h00, len};
                if (sq_left != 0) arm_write(FK_SE); else complete();
            end
            CMD_RDSTATUS: open_frame(FK_RDSR);
            CMD_WRSTATUS: arm_write(FK_WRSR);
            CMD_MANUID:   open_frame(FK_MID);
            CMD_UNIQUEID: open_frame(FK_UID);
            default:      open_frame(FK_JID);
        endcase
        return 1'b1;
    endfunction

    function out_item_t sequence_beat(in_item_t it);
        bit ok;
        sq_res = '0;
        ok = 1'b1;
        case (sq_phase)
            PH_IDLE:
                if (it.opcode != OP_START) ok = 1'b0;
                else ok = launch(it.command, it.address, it.length);
            PH_HOST:
                if (it.opcode != OP_HOST) ok = 1'b0;
                else begin
                    shift_out(it.data_byte, sq_fidx + 1 == sq_flen);
                    sq_phase = PH_FRAME;
                end
            PH_WREN:
                if (it.opcode != OP_FLASH) ok = 1'b0;
                else open_frame(sq_kind);
            PH_FRAME:
                if (it.opcode != OP_FLASH) ok = 1'b0;
                else begin
                    if (returns_data(sq_kind) && sq_fidx >= header_len(sq_kind)) begin
                        sq_res.rx_valid = 1'b1;
                        sq_res.rx_byte  = it.spi_byte;
                    end
                    sq_fidx++;
                    if (sq_fidx >= sq_flen) begin
                        if (sq_kind == FK_SE || sq_kind == FK_PP || sq_kind == FK_WRSR)
                            poll_status();
                        else
                            complete();
                    end else begin
                        next_frame_byte();
                    end
                end
            PH_POLL_CMD:
                if (it.opcode != OP_FLASH) ok = 1'b0;
                else begin
                    sq_pidx = 1'b0;
                    sq_phase = PH_POLL_RD;
                    shift_out(8'h00, 1'b0);
                end
            default:
                if (it.opcode != OP_FLASH) ok = 1'b0;
                else if (!sq_pidx) begin
                    sq_pidx = 1'b1;
                    shift_out(8'h00, 1'b1);
                end else if ((it.spi_byte & BUSY_MASK) != 0) begin
                    poll_status();
                end else begin
                    ready_again();
                end
        endcase
        if (!ok) begin
            sq_res = '0;
            sq_res.rejected = 1'b1;
        end
        return sq_res;
    endfunction

    function in_item_t random_beat();
        in_item_t it;
        it.opcode    = 2'($urandom);
        it.command   = 4'($urandom);
        it.address   = 24'($urandom);
        it.length    = 24'($urandom);
        it.data_byte = 8'($urandom);
        it.spi_byte  = 8'($urandom);
        return it;
    endfunction

    task automatic queue_beat(in_item_t it);
        staged_q.push_back(sequence_beat(it));
        beat_q.push_back(it);
        drain_q.push_back(drain_next);
        drain_next = 1'b0;
        beats_in++;
    endtask

    task automatic answer_beat(bit noisy);
        in_item_t it;
        logic [1:0] want;
        it = random_beat();
        want = (sq_phase == PH_HOST) ? OP_HOST : OP_FLASH;
        if (noisy && $urandom_range(0, 19) == 0) begin
            do it.opcode = 2'($urandom); while (it.opcode == want);
        end else begin
            it.opcode = want;
            if (sq_phase == PH_POLL_RD && sq_pidx)
                it.spi_byte[0] = ($urandom_range(0, 3) == 0);
        end
        queue_beat(it);
    endtask

    task automatic run_command(logic [3:0] cmd, logic [23:0] addr, logic [23:0] len,
                               bit noisy);
        in_item_t it;
        it = random_beat();
        it.opcode  = OP_START;
        it.command = cmd;
        it.address = addr;
        it.length  = len;
        queue_beat(it);
        starts_made++;
        while (sq_phase != PH_IDLE) answer_beat(noisy);
    endtask

    task automatic build_stimulus();
        in_item_t it;
        logic [3:0] cmd;
        logic [23:0] len;
        // rejected in idle
        it = random_beat(); it.opcode = OP_HOST;  queue_beat(it);
        it = random_beat(); it.opcode = 2'd3;     queue_beat(it);
        it = random_beat(); it.opcode = OP_START; it.command = 4'd9;  queue_beat(it);
        it = random_beat(); it.opcode = OP_START; it.command = 4'd15; queue_beat(it);
        run_command(CMD_READ, 24'h000000, 24'd0, 1'b0);
        run_command(CMD_READ, 24'hFFFFFF, 24'd3, 1'b0);
        run_command(CMD_ERASE, 24'h000000, 24'd0, 1'b0);
        run_command(CMD_ERASE, 24'hFFFFFF, 24'd1, 1'b0);
        run_command(CMD_ERASE, 24'hFFF000, 24'd8193, 1'b0);
        run_command(CMD_WRITE, 24'h000000, 24'd0, 1'b0);
        run_command(CMD_WRITE, 24'hFFFFFF, 24'd1, 1'b1);
        run_command(CMD_ERASE_WR, 24'h000000, 24'd0, 1'b0);
        run_command(CMD_ERASE_WR, 24'h000001, 24'd20, 1'b0);
        run_command(CMD_ERASE_WR, 24'hFFFFFF, 24'd5, 1'b0);
        run_command(CMD_RDSTATUS, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        run_command(CMD_WRSTATUS, 24'h000000, 24'h000000, 1'b1);
        run_command(CMD_MANUID, 24'($urandom), 24'($urandom), 1'b0);
        run_command(CMD_UNIQUEID, 24'($urandom), 24'($urandom), 1'b0);
        run_command(CMD_JEDEC, 24'($urandom), 24'($urandom), 1'b1);
        drain_next = 1'b1;
        while (beats_in < 750 || sq_phase != PH_IDLE) begin
            if (beats_in > 550 && beats_in < 560) drain_next = 1'b1;
            if ($urandom_range(0, 11) == 0) begin
                it = random_beat();
                if ($urandom_range(0, 1) == 0) begin
                    it.opcode = 2'($urandom_range(1, 3));
                end else begin
                    it.opcode = OP_START;
                    it.command = 4'($urandom_range(9, 15));
                end
                queue_beat(it);
            end else begin
                cmd = 4'($urandom_range(0, 8));
                if (cmd == CMD_WRITE && beats_in > 400) cmd = CMD_ERASE_WR;
                case (cmd)
                    CMD_READ:     len = 24'($urandom_range(0, 24));
                    CMD_ERASE:    len = 24'($urandom_range(0, 9000));
                    CMD_WRITE:    len = 24'($urandom_range(0, 256));
                    CMD_ERASE_WR: len = 24'($urandom_range(0, 48));
                    default:      len = 24'($urandom);
                endcase
                run_command(cmd, 24'($urandom), len, 1'b1);
            end
        end
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // drive at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            quiet <= (beat_q.size() < 120);
            if (!s_valid || accepted) begin
                if (gap_in > 0) begin
                    gap_in <= gap_in - 1;
                    s_valid <= 1'b0;
                end else if (beat_q.size() > 0 && !(drain_q[0] && awaited_q.size() != 0)) begin
                    s_data <= beat_q.pop_front();
                    void'(drain_q.pop_front());
                    s_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0) gap_in <= $urandom_range(1, 14);
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (gap_out > 0) begin
                gap_out <= gap_out - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) gap_out <= $urandom_range(1, 14);
            end
        end
    end

    // sample at the rising edge
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            accepted <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_out++;
                if (awaited_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    want = awaited_q.pop_front();
                    check_field("tx_valid", 8'(want.tx_valid), 8'(m_data.tx_valid));
                    check_field("tx_byte", want.tx_byte, m_data.tx_byte);
                    check_field("frame_end", 8'(want.frame_end), 8'(m_data.frame_end));
                    check_field("rx_valid", 8'(want.rx_valid), 8'(m_data.rx_valid));
                    check_field("rx_byte", want.rx_byte, m_data.rx_byte);
                    check_field("need_data", 8'(want.need_data), 8'(m_data.need_data));
                    check_field("done_res", 8'(want.done_res), 8'(m_data.done_res));
                    check_field("rejected", 8'(want.rejected), 8'(m_data.rejected));
                end
            end
            if (s_valid && s_ready) awaited_q.push_back(staged_q.pop_front());
            accepted <= s_valid && s_ready;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        starts_made = 0;
        gap_in = 0;
        gap_out = 0;
        quiet = 1'b0;
        drain_next = 1'b0;
        sq_phase = PH_IDLE;
        sq_kind = FK_NONE;
        sq_cmd = CMD_READ;
        sq_ptr = '0;
        sq_left = 0;
        sq_fidx = 0;
        sq_flen = 0;
        sq_pages = 0;
        sq_pidx = 1'b0;
        build_stimulus();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        do @(posedge aclk);
        while (beat_q.size() != 0 || staged_q.size() != 0 || awaited_q.size() != 0);
        repeat (8) @(posedge aclk);
        if (awaited_q.size() != 0) begin
            $error("results still outstanding at end");
            errors++;
        end
        $display("Covered %0d beats in %0d commands; %0d result beats checked.",
                 beats_in, starts_made, beats_out);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
